FILE: hdl/ps2_mouse_packet_decoder_unit_assert.svh
// assertion macros shared by the ps/2 mouse packet decoder modules
// no dependencies; included by the modules that carry checks
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PMPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pmpd same-cycle check failed");

// next-cycle implication, checked out of reset
`define PMPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pmpd next-cycle check failed");

`endif

FILE: hdl/pmpd_pkg.sv
// types and constants for the ps/2 mouse packet decoder
// no dependencies; used by all pmpd modules
package pmpd_pkg;

    localparam int ByteWidth      = 8;
    localparam int ButtonWidth    = 5;
    localparam int MoveWidth      = 9;
    localparam int WheelWidth     = 16;
    localparam int TdataOutWidth  = 56;
    localparam int CfgIndexWidth  = 1;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_WHEEL       = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_FIVE_BUTTON = 1'b1;

    // wheel codes in the low nibble of the extra byte
    localparam logic [3:0] WHEEL_Y_INC = 4'h1;
    localparam logic [3:0] WHEEL_X_INC = 4'h2;
    localparam logic [3:0] WHEEL_X_DEC = 4'hE;
    localparam logic [3:0] WHEEL_Y_DEC = 4'hF;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2,
        POS_EXTRA  = 2'd3
    } pos_t;

    typedef struct packed {
        logic wheel_en;
        logic five_btn_en;
    } cfg_t;

    typedef struct packed {
        logic [ByteWidth-1:0] header;
        logic [ByteWidth-1:0] x;
        logic [ByteWidth-1:0] y;
        logic [ByteWidth-1:0] extra;
    } pkt_t;

endpackage

FILE: hdl/pmpd_assembler.sv
// gathers mouse bytes into a three or four byte packet and holds it in a packet register
// depends on pmpd_pkg and ps2_mouse_packet_decoder_unit_assert.svh
`include "ps2_mouse_packet_decoder_unit_assert.svh"

module pmpd_assembler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pmpd_pkg::ByteWidth-1:0] in_byte,
    input  logic                           four_byte,
    output logic                           pkt_valid,
    output pmpd_pkg::pkt_t                 pkt,
    input  logic                           pkt_take
);

    pmpd_pkg::pos_t pos_reg, pos_next;
    logic [pmpd_pkg::ByteWidth-1:0] header_reg, x_reg, y_reg;
    logic                           pkt_valid_reg, pkt_valid_next;
    pmpd_pkg::pkt_t                 pkt_reg, pkt_next;
    logic                           fire;
    logic                           complete;

    assign in_ready  = !pkt_valid_reg || pkt_take;
    assign fire      = in_valid && in_ready;
    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

    always_comb begin
        pos_next = pos_reg;
        if (fire) begin
            case (pos_reg)
                pmpd_pkg::POS_HEADER: pos_next = pmpd_pkg::POS_X;
                pmpd_pkg::POS_X:      pos_next = pmpd_pkg::POS_Y;
                pmpd_pkg::POS_Y: begin
                    pos_next = four_byte ? pmpd_pkg::POS_EXTRA : pmpd_pkg::POS_HEADER;
                end
                pmpd_pkg::POS_EXTRA:  pos_next = pmpd_pkg::POS_HEADER;
                default:              pos_next = pmpd_pkg::POS_HEADER;
            endcase
        end
    end

    always_comb begin
        complete = fire && (((pos_reg == pmpd_pkg::POS_Y) && !four_byte) ||
                            (pos_reg == pmpd_pkg::POS_EXTRA));
        pkt_next.header = header_reg;
        pkt_next.x      = x_reg;
        pkt_next.y      = (pos_reg == pmpd_pkg::POS_Y) ? in_byte : y_reg;
        // a three byte packet has no extra byte: it reads as zero
        pkt_next.extra  = (pos_reg == pmpd_pkg::POS_EXTRA) ? in_byte : '0;
        if (complete) begin
            pkt_valid_next = 1'b1;
        end else if (pkt_take) begin
            pkt_valid_next = 1'b0;
        end else begin
            pkt_valid_next = pkt_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= pmpd_pkg::POS_HEADER;
            pkt_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && (pos_reg == pmpd_pkg::POS_HEADER)) begin
            header_reg <= in_byte;
        end
        if (fire && (pos_reg == pmpd_pkg::POS_X)) begin
            x_reg <= in_byte;
        end
        if (fire && (pos_reg == pmpd_pkg::POS_Y)) begin
            y_reg <= in_byte;
        end
        if (complete) begin
            pkt_reg <= pkt_next;
        end
    end

    `PMPD_ASSERT_NEXT(a_header_then_x, aclk, aresetn,
        fire && (pos_reg == pmpd_pkg::POS_HEADER), pos_reg == pmpd_pkg::POS_X)
    `PMPD_ASSERT_NEXT(a_short_packet_out, aclk, aresetn,
        fire && (pos_reg == pmpd_pkg::POS_Y) && !four_byte,
        pkt_valid_reg && (pkt_reg.extra == '0))
    `PMPD_ASSERT_NEXT(a_packet_source, aclk, aresetn,
        !pkt_valid_reg || pkt_take,
        !pkt_valid_reg || $past(fire && ((pos_reg == pmpd_pkg::POS_Y) ||
                                         (pos_reg == pmpd_pkg::POS_EXTRA))))

endmodule

FILE: hdl/pmpd_decoder.sv
// decodes a held packet: buttons, sign-extended deltas, wheel counters, result register
// depends on pmpd_pkg and ps2_mouse_packet_decoder_unit_assert.svh
`include "ps2_mouse_packet_decoder_unit_assert.svh"

module pmpd_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pmpd_pkg::cfg_t                   cfg,
    input  logic                             pkt_valid,
    input  pmpd_pkg::pkt_t                   pkt,
    output logic                             pkt_take,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pmpd_pkg::ButtonWidth-1:0] button_bits,
    output logic [pmpd_pkg::MoveWidth-1:0]   move_x,
    output logic [pmpd_pkg::MoveWidth-1:0]   move_y,
    output logic [pmpd_pkg::WheelWidth-1:0]  wheel_horizontal,
    output logic [pmpd_pkg::WheelWidth-1:0]  wheel_vertical,
    output logic                             overflow_dropped
);

    logic [pmpd_pkg::ButtonWidth-1:0] button_reg, button_next;
    logic [pmpd_pkg::WheelWidth-1:0]  wheel_x_reg, wheel_x_next;
    logic [pmpd_pkg::WheelWidth-1:0]  wheel_y_reg, wheel_y_next;
    logic [pmpd_pkg::MoveWidth-1:0]   move_x_next, move_y_next;
    logic                             dropped;
    logic                             out_valid_reg, out_valid_next;

    logic [pmpd_pkg::ButtonWidth-1:0] out_button_reg;
    logic [pmpd_pkg::MoveWidth-1:0]   out_move_x_reg, out_move_y_reg;
    logic [pmpd_pkg::WheelWidth-1:0]  out_wheel_x_reg, out_wheel_y_reg;
    logic                             out_dropped_reg;

    assign pkt_take = pkt_valid && (!out_valid_reg || out_ready);

    always_comb begin
        dropped      = |pkt.header[7:6];
        button_next  = button_reg;
        wheel_x_next = wheel_x_reg;
        wheel_y_next = wheel_y_reg;
        move_x_next  = '0;
        move_y_next  = '0;
        if (!dropped) begin
            // left and right swap places against the header order
            button_next = {button_reg[4:3], pkt.header[2], pkt.header[0], pkt.header[1]};
            if (cfg.five_btn_en) begin
                button_next[4:3] = {pkt.extra[5], pkt.extra[4]};
            end
            move_x_next = {pkt.header[4], pkt.x};
            move_y_next = {pkt.header[5], pkt.y};
            if (cfg.wheel_en) begin
                case (pkt.extra[3:0])
                    pmpd_pkg::WHEEL_Y_INC: wheel_y_next = wheel_y_reg + 16'd1;
                    pmpd_pkg::WHEEL_X_INC: wheel_x_next = wheel_x_reg + 16'd1;
                    pmpd_pkg::WHEEL_X_DEC: wheel_x_next = wheel_x_reg - 16'd1;
                    pmpd_pkg::WHEEL_Y_DEC: wheel_y_next = wheel_y_reg - 16'd1;
                    default: ;
                endcase
            end
        end
        if (pkt_take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_reg    <= '0;
            wheel_x_reg   <= '0;
            wheel_y_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pkt_take) begin
                button_reg  <= button_next;
                wheel_x_reg <= wheel_x_next;
                wheel_y_reg <= wheel_y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_take) begin
            out_button_reg  <= button_next;
            out_move_x_reg  <= move_x_next;
            out_move_y_reg  <= move_y_next;
            out_wheel_x_reg <= wheel_x_next;
            out_wheel_y_reg <= wheel_y_next;
            out_dropped_reg <= dropped;
        end
    end

    assign out_valid        = out_valid_reg;
    assign button_bits      = out_button_reg;
    assign move_x           = out_move_x_reg;
    assign move_y           = out_move_y_reg;
    assign wheel_horizontal = out_wheel_x_reg;
    assign wheel_vertical   = out_wheel_y_reg;
    assign overflow_dropped = out_dropped_reg;

    `PMPD_ASSERT_NOW(a_dropped_no_motion, aclk, aresetn,
        out_valid_reg && out_dropped_reg, (out_move_x_reg == '0) && (out_move_y_reg == '0))
    `PMPD_ASSERT_NEXT(a_dropped_keeps_state, aclk, aresetn,
        pkt_take && dropped,
        $stable(button_reg) && $stable(wheel_x_reg) && $stable(wheel_y_reg))
    `PMPD_ASSERT_NEXT(a_three_buttons_keep_upper, aclk, aresetn,
        pkt_take && !cfg.five_btn_en, button_reg[4:3] == $past(button_reg[4:3]))

endmodule

FILE: hdl/ps2_mouse_packet_decoder_unit.sv
// top level of the ps/2 mouse packet decoder: configuration registers and stream ports
// depends on pmpd_pkg, pmpd_assembler and pmpd_decoder
//
//   channel   dir   handshake              payload
//   s_        in    s_tvalid / s_tready    s_tdata: data byte
//   m_        out   m_tvalid / m_tready    m_tdata: buttons, moves, wheels; m_tuser: dropped
//   cfg_      in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte is taken every cycle while s_tready is high; a packet's result passes through
// the packet register, then the result register
// reset clears the byte position, buttons, wheel counters and both registers' valid flags
// a stalled result backs up into the packet register; bytes that do not end a packet are
// still taken until the packet register is full
// cfg_ready is always high

module ps2_mouse_packet_decoder_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pmpd_pkg::ByteWidth-1:0]       s_tdata,   // [7:0] data_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [4:0] button_bits, [13:5] move_x, [22:14] move_y, [38:23] wheel_horizontal,
    // [54:39] wheel_vertical, [55] zero
    output logic [pmpd_pkg::TdataOutWidth-1:0]   m_tdata,
    output logic                                 m_tuser,   // [0] overflow_dropped
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmpd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic                                 cfg_data
);

    pmpd_pkg::cfg_t cfg_reg;
    pmpd_pkg::pkt_t pkt;
    logic           pkt_valid;
    logic           pkt_take;
    logic           dec_in_ready;

    logic [pmpd_pkg::ButtonWidth-1:0] button_bits;
    logic [pmpd_pkg::MoveWidth-1:0]   move_x, move_y;
    logic [pmpd_pkg::WheelWidth-1:0]  wheel_horizontal, wheel_vertical;
    logic                             overflow_dropped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pmpd_pkg::CFG_WHEEL:       cfg_reg.wheel_en    <= cfg_data;
                pmpd_pkg::CFG_FIVE_BUTTON: cfg_reg.five_btn_en <= cfg_data;
                default: ;
            endcase
        end
    end

    pmpd_assembler u_assembler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (dec_in_ready),
        .in_byte   (s_tdata),
        .four_byte (cfg_reg.wheel_en || cfg_reg.five_btn_en),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .pkt_take  (pkt_take)
    );

    assign s_tready = dec_in_ready;

    pmpd_decoder u_decoder (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .pkt_valid        (pkt_valid),
        .pkt              (pkt),
        .pkt_take         (pkt_take),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .button_bits      (button_bits),
        .move_x           (move_x),
        .move_y           (move_y),
        .wheel_horizontal (wheel_horizontal),
        .wheel_vertical   (wheel_vertical),
        .overflow_dropped (overflow_dropped)
    );

    assign m_tdata = {1'b0, wheel_vertical, wheel_horizontal, move_y, move_x, button_bits};
    assign m_tuser = overflow_dropped;

endmodule
